// ===== design/e2r_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler angle to rotation matrix block.
package e2r_pkg;

	localparam int unsigned QW = 34;

	localparam logic signed [QW-1:0] Q_ONE = QW'(64'sd1073741824);

	typedef struct packed {
		logic signed [15:0] angle_x_deg;
		logic signed [15:0] angle_y_deg;
		logic signed [15:0] angle_z_deg;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] elem_r0_c0;
		logic signed [15:0] elem_r0_c1;
		logic signed [15:0] elem_r0_c2;
		logic signed [15:0] elem_r1_c0;
		logic signed [15:0] elem_r1_c1;
		logic signed [15:0] elem_r1_c2;
		logic signed [15:0] elem_r2_c0;
		logic signed [15:0] elem_r2_c1;
		logic signed [15:0] elem_r2_c2;
	} out_item_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// One angle as it travels along the row.
	typedef struct packed {
		quad_t                  quad;
		logic                   swap;
		logic signed [QW-1:0]   r;
		logic signed [QW-1:0]   r2;
		logic signed [QW-1:0]   s;
		logic signed [QW-1:0]   c;
	} ang_t;

	typedef struct packed {
		ang_t ax;
		ang_t ay;
		ang_t az;
	} tri_t;

	// Round to nearest, ties toward plus infinity, drop 30 fraction bits.
	function automatic logic signed [QW-1:0] rnd30(input logic signed [67:0] v);
		logic signed [67:0] t;
		begin
			t = v + 68'sd536870912;
			rnd30 = QW'(t >>> 30);
		end
	endfunction

	// Divide by a small constant, truncating toward zero. The magnitude stays
	// below 2^31; m = ceil(2^sh / k) with sh = 31 + clog2(k) gives the exact
	// quotient for every such magnitude.
	function automatic logic signed [QW-1:0] div_k(input logic signed [QW-1:0] v,
		input logic [31:0] m, input int unsigned sh);
		logic [30:0]   mag;
		logic [62:0]   prod;
		logic [QW-1:0] qt;
		begin
			mag  = v[QW-1] ? 31'(-v) : 31'(v);
			prod = 63'(mag) * 63'(m);
			qt   = QW'(prod >> sh);
			div_k = v[QW-1] ? -$signed(qt) : $signed(qt);
		end
	endfunction

	function automatic int unsigned sin_div(input int unsigned i);
		case (i)
			0: sin_div = 110;
			1: sin_div = 72;
			2: sin_div = 42;
			3: sin_div = 20;
			default: sin_div = 6;
		endcase
	endfunction

	function automatic int unsigned cos_div(input int unsigned i);
		case (i)
			0: cos_div = 132;
			1: cos_div = 90;
			2: cos_div = 56;
			3: cos_div = 30;
			4: cos_div = 12;
			default: cos_div = 2;
		endcase
	endfunction

endpackage

// ===== design/e2r_reduce.sv =====
// Angle reduction to octant, quadrant and radians for one angle.
module e2r_reduce (
	input  logic               clk,
	input  logic               en,
	input  logic        [15:0] angle,
	output e2r_pkg::ang_t      ang_s3
);
	import e2r_pkg::*;

	// pi in Q2.30 split as 11520 * RAD_INT + RAD_REM; RAD_RECIP = ceil(2^39 / 11520)
	localparam logic [29:0] RAD_INT   = 30'd292817;
	localparam logic [24:0] RAD_REM   = 25'd7586;
	localparam logic [50:0] RAD_RECIP = 51'd47721859;

	logic signed [15:0] a_wrap;
	logic        [14:0] a_mod;
	logic        [1:0]  q_c;
	logic        [12:0] t_c;
	logic        [12:0] u_c;
	logic               sw_c;
	logic        [12:0] u_s1;
	logic        [1:0]  q_s1;
	logic               sw_s1;
	logic        [29:0] base_s2;
	logic        [24:0] num_s2;
	logic        [1:0]  q_s2;
	logic               sw_s2;
	logic        [10:0] corr_c;

	always_comb begin
		a_wrap = $signed(angle);
		// one subtract for positive angles, up to two adds for negative ones: |angle| < 2 turns
		if (a_wrap >= 16'sd23040)
			a_wrap = a_wrap - 16'sd23040;
		else if (a_wrap < 0) begin
			a_wrap = a_wrap + 16'sd23040;
			if (a_wrap < 0)
				a_wrap = a_wrap + 16'sd23040;
		end
		a_mod = a_wrap[14:0];
		if (a_mod >= 15'd17280)
			q_c = 2'd3;
		else if (a_mod >= 15'd11520)
			q_c = 2'd2;
		else if (a_mod >= 15'd5760)
			q_c = 2'd1;
		else
			q_c = 2'd0;
		t_c  = 13'(a_mod - 15'(q_c) * 15'd5760);
		sw_c = t_c > 13'd2880;
		u_c  = sw_c ? 13'd5760 - t_c : t_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= u_c;
			q_s1  <= q_c;
			sw_s1 <= sw_c;
		end
	end

	// Radians: whole part of u * pi / 11520 plus the quotient of the remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			base_s2 <= 30'(u_s1) * RAD_INT;
			num_s2  <= 25'(u_s1) * RAD_REM + 25'd5760;
			q_s2    <= q_s1;
			sw_s2   <= sw_s1;
		end
	end

	assign corr_c = 11'((51'(num_s2) * RAD_RECIP) >> 39);

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s3.quad <= quad_t'(q_s2);
			ang_s3.swap <= sw_s2;
			ang_s3.r    <= QW'(base_s2) + QW'(corr_c);
			ang_s3.r2   <= '0;
			ang_s3.s    <= Q_ONE;
			ang_s3.c    <= Q_ONE;
		end
	end

endmodule

// ===== design/e2r_cell.sv =====
// One series cell for the sine and cosine of three angles, product then divide: r squared, a Horner step or sine scale.
module e2r_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic          clk,
	input  logic          en,
	input  e2r_pkg::tri_t d,
	output e2r_pkg::tri_t q_s2
);
	import e2r_pkg::*;

	localparam int unsigned SDIV = sin_div((IDX == 0) ? 0 : IDX - 1);
	localparam int unsigned CDIV = cos_div((IDX == 0) ? 0 : IDX - 1);
	localparam int unsigned SSH  = 31 + $clog2(SDIV);
	localparam int unsigned CSH  = 31 + $clog2(CDIV);
	localparam logic [31:0] SMUL = 32'(((64'd1 << SSH) + 64'(SDIV) - 64'd1) / 64'(SDIV));
	localparam logic [31:0] CMUL = 32'(((64'd1 << CSH) + 64'(CDIV) - 64'd1) / 64'(CDIV));

	tri_t mid_s1;

	// First half: the products; s and c carry them to the second half.
	function automatic ang_t prod_step(input ang_t a);
		ang_t o;
		begin
			o = a;
			if (IDX == 0)
				o.r2 = rnd30(68'(a.r) * 68'(a.r));
			else if (IDX <= 6) begin
				if (IDX <= 5)
					o.s = rnd30(68'(a.r2) * 68'(a.s));
				o.c = rnd30(68'(a.r2) * 68'(a.c));
			end else if (IDX == 7)
				o.s = rnd30(68'(a.r) * 68'(a.s));
			prod_step = o;
		end
	endfunction

	// Second half: divide and subtract from one.
	function automatic ang_t div_step(input ang_t a);
		ang_t o;
		begin
			o = a;
			if (IDX >= 1 && IDX <= 6) begin
				if (IDX <= 5)
					o.s = Q_ONE - div_k(a.s, SMUL, SSH);
				o.c = Q_ONE - div_k(a.c, CMUL, CSH);
			end
			div_step = o;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1.ax <= prod_step(d.ax);
			mid_s1.ay <= prod_step(d.ay);
			mid_s1.az <= prod_step(d.az);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2.ax <= div_step(mid_s1.ax);
			q_s2.ay <= div_step(mid_s1.ay);
			q_s2.az <= div_step(mid_s1.az);
		end
	end

endmodule

// ===== design/e2r_matrix.sv =====
// Quadrant fold, matrix products and output rounding.
module e2r_matrix #(
	parameter int unsigned OUT_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               en,
	input  e2r_pkg::tri_t      d,
	output e2r_pkg::out_item_t q_s3
);
	import e2r_pkg::*;

	localparam int unsigned SH = 30 - OUT_FRAC_BITS;

	logic signed [QW-1:0] sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	logic signed [QW-1:0] sxsz_s2, sxcz_s2;
	logic signed [QW-1:0] sx_s2, cx_s2, sy_s2, cy_s2, sz_s2, cz_s2;
	logic signed [QW-1:0] e_c [9];

	function automatic logic signed [2*QW-1:0] fold(input ang_t a);
		logic signed [QW-1:0] s0, c0, sn, cs;
		begin
			s0 = a.swap ? a.c : a.s;
			c0 = a.swap ? a.s : a.c;
			case (a.quad)
				QUAD_0: begin sn = s0; cs = c0; end
				QUAD_1: begin sn = c0; cs = -s0; end
				QUAD_2: begin sn = -s0; cs = -c0; end
				default: begin sn = -c0; cs = s0; end
			endcase
			fold = {sn, cs};
		end
	endfunction

	function automatic logic signed [15:0] to_out(input logic signed [QW-1:0] e);
		logic signed [QW-1:0] v;
		logic signed [QW-1:0] lim;
		begin
			lim = QW'(64'sd1 << OUT_FRAC_BITS);
			if (SH > 0)
				v = QW'((68'(e) + (68'sd1 <<< (SH - 1))) >>> SH);
			else
				v = e;
			if (v > lim)
				v = lim;
			if (v < -lim)
				v = -lim;
			to_out = v[15:0];
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			{sx_s1, cx_s1} <= fold(d.ax);
			{sy_s1, cy_s1} <= fold(d.ay);
			{sz_s1, cz_s1} <= fold(d.az);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sxsz_s2 <= rnd30(68'(sx_s1) * 68'(sz_s1));
			sxcz_s2 <= rnd30(68'(sx_s1) * 68'(cz_s1));
			sx_s2 <= sx_s1; cx_s2 <= cx_s1; sy_s2 <= sy_s1;
			cy_s2 <= cy_s1; sz_s2 <= sz_s1; cz_s2 <= cz_s1;
		end
	end

	always_comb begin
		e_c[0] = rnd30(68'(cy_s2) * 68'(cz_s2) + 68'(sy_s2) * 68'(sxsz_s2));
		e_c[1] = rnd30(68'(sy_s2) * 68'(sxcz_s2) - 68'(cy_s2) * 68'(sz_s2));
		e_c[2] = rnd30(68'(sy_s2) * 68'(cx_s2));
		e_c[3] = rnd30(68'(cx_s2) * 68'(sz_s2));
		e_c[4] = rnd30(68'(cx_s2) * 68'(cz_s2));
		e_c[5] = -sx_s2;
		e_c[6] = rnd30(68'(cy_s2) * 68'(sxsz_s2) - 68'(sy_s2) * 68'(cz_s2));
		e_c[7] = rnd30(68'(sy_s2) * 68'(sz_s2) + 68'(cy_s2) * 68'(sxcz_s2));
		e_c[8] = rnd30(68'(cy_s2) * 68'(cx_s2));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3.elem_r0_c0 <= to_out(e_c[0]);
			q_s3.elem_r0_c1 <= to_out(e_c[1]);
			q_s3.elem_r0_c2 <= to_out(e_c[2]);
			q_s3.elem_r1_c0 <= to_out(e_c[3]);
			q_s3.elem_r1_c1 <= to_out(e_c[4]);
			q_s3.elem_r1_c2 <= to_out(e_c[5]);
			q_s3.elem_r2_c0 <= to_out(e_c[6]);
			q_s3.elem_r2_c1 <= to_out(e_c[7]);
			q_s3.elem_r2_c2 <= to_out(e_c[8]);
		end
	end

endmodule

// ===== design/euler_to_rotation_matrix.sv =====
// Top level: Euler angles (Y*X*Z order) to a fixed point rotation matrix.
// Throughput: one item per cycle when the output is not stalled; every stage, including
// both halves of each series cell, takes a new item in every cycle in which it advances.
// The whole pipeline advances when its last stage is free, so a stall on the
// output holds every stage.
// Reset: arst_n clears the stage valid bits only; data registers are not reset.
module euler_to_rotation_matrix #(
	parameter int unsigned OUT_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  e2r_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output e2r_pkg::out_item_t  out_data
);
	import e2r_pkg::*;

	localparam int unsigned LAT = 3 + 16 + 3;

	logic [LAT-1:0] vld_q;
	logic           adv;
	tri_t           row [9];
	ang_t           ax_s3, ay_s3, az_s3;
	out_item_t      res_s3;

	// Advance whenever the output is free or being taken.
	assign adv      = !vld_q[LAT-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// Every datapath register loads only on advance: hold every stage when stalled.
	e2r_reduce u_rx (.clk(clk), .en(adv), .angle(in_data.angle_x_deg), .ang_s3(ax_s3));
	e2r_reduce u_ry (.clk(clk), .en(adv), .angle(in_data.angle_y_deg), .ang_s3(ay_s3));
	e2r_reduce u_rz (.clk(clk), .en(adv), .angle(in_data.angle_z_deg), .ang_s3(az_s3));

	assign row[0] = '{ax: ax_s3, ay: ay_s3, az: az_s3};

	// Row of cells: r squared, five sine/six cosine Horner steps, final sine scale.
	for (genvar i = 0; i < 8; i++) begin : g_cell
		e2r_cell #(.IDX(i)) u_cell (.clk(clk), .en(adv), .d(row[i]), .q_s2(row[i+1]));
	end

	e2r_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat (
		.clk(clk), .en(adv), .d(row[8]), .q_s3(res_s3));

	assign out_valid = vld_q[LAT-1];
	assign out_data  = res_s3;

	ap_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid) |-> in_ready)
		else $error("input blocked with empty output");
	ap_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

endmodule
